@@ design/skse_pkg.sv @@
// shared types and codes for the sorted key set engine
package skse_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT    = 2'd0,
      FUNC_REMOVE    = 2'd1,
      FUNC_LIST_ASC  = 2'd2,
      FUNC_LIST_DESC = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_REMOVED   = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_LISTED    = 3'd5,
      STATUS_EMPTY     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT_UP,
      ST_PLACE,
      ST_SHIFT_DN,
      ST_LIST,
      ST_RESP
   } seq_state_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value;
      logic               last;
      logic [4:0]         occupancy;
   } rsp_type;

endpackage

@@ design/skse_if.sv @@
// valid/ready channel interfaces for requests and responses

interface skse_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] key;

   modport source (output valid, output func, output key, input ready);
   modport sink (input valid, input func, input key, output ready);
endinterface

interface skse_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] value;
   logic               last;
   logic [4:0]         occupancy;

   modport source (output valid, output status, output value, output last,
                   output occupancy, input ready);
   modport sink (input valid, input status, input value, input last,
                 input occupancy, output ready);
endinterface

@@ design/skse_mem.sv @@
// key table memory: one write port, one read port with registered data
module skse_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic signed [31:0]    wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic signed [31:0]    rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/skse_seq.sv @@
// sequencer: search, shift and listing passes over the key table
module skse_seq
   import skse_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int AW       = 4,
   parameter int CNT_W    = 5
) (
   input  logic               clock,
   input  logic               reset,
   skse_req_if.sink           req_ch,
   input  logic               rsp_free,
   output logic               rsp_load,
   output rsp_type            rsp_data,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic signed [31:0] wr_data,
   output logic [AW-1:0]      rd_addr,
   input  logic signed [31:0] rd_data
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   func_type           func_ff, func_in;
   logic signed [31:0] key_ff, key_in;
   status_type         status_ff, status_in;

   logic               key_lt;
   logic               key_eq;
   logic               at_end;
   logic               list_last;
   logic [CNT_W-1:0]   ptr_inc;
   logic [CNT_W-1:0]   ptr_dec;

   // the one shared compare unit
   assign key_lt  = rd_data < key_ff;
   assign key_eq  = rd_data == key_ff;
   assign at_end  = ptr_ff == count_ff;
   assign ptr_inc = ptr_ff + ONE;
   assign ptr_dec = ptr_ff - ONE;
   assign list_last = (func_ff == FUNC_LIST_ASC) ? (ptr_ff == count_ff - ONE)
                                                 : (ptr_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      func_ff   <= func_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      func_in   = func_ff;
      key_in    = key_ff;
      status_in = status_ff;

      wr_en   = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = rd_data;

      rsp_load           = 1'b0;
      rsp_data.status    = status_ff;
      rsp_data.value     = (status_ff == STATUS_EMPTY) ? 32'sd0 : key_ff;
      rsp_data.last      = 1'b1;
      rsp_data.occupancy = 5'(count_ff);

      req_ch.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in = func_type'(req_ch.func);
               key_in  = req_ch.key;
               unique case (func_type'(req_ch.func))
                  FUNC_INSERT, FUNC_REMOVE: begin
                     ptr_in   = '0;
                     state_in = ST_SEARCH;
                  end
                  FUNC_LIST_ASC: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        ptr_in   = '0;
                        state_in = ST_LIST;
                     end
                  end
                  FUNC_LIST_DESC: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        ptr_in   = count_ff - ONE;
                        state_in = ST_LIST;
                     end
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (func_ff == FUNC_INSERT) begin
               // stop at the first entry not below the key
               if (at_end || !key_lt) begin
                  if (!at_end && key_eq) begin
                     status_in = STATUS_DUPLICATE;
                     state_in  = ST_RESP;
                  end else if (count_ff == CAP_CNT) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     pos_in = ptr_ff;
                     if (at_end) begin
                        state_in = ST_PLACE;
                     end else begin
                        ptr_in   = count_ff - ONE;
                        state_in = ST_SHIFT_UP;
                     end
                  end
               end else begin
                  ptr_in = ptr_inc;
               end
            end else begin
               if (at_end) begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = ST_RESP;
               end else if (key_eq) begin
                  ptr_in   = ptr_inc;
                  state_in = ST_SHIFT_DN;
               end else begin
                  ptr_in = ptr_inc;
               end
            end
         end

         ST_SHIFT_UP: begin
            // move entry ptr one place up, walking down to the insert slot
            wr_en   = 1'b1;
            wr_addr = ptr_inc[AW-1:0];
            if (ptr_ff == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               ptr_in = ptr_dec;
            end
         end

         ST_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = pos_ff[AW-1:0];
            wr_data   = key_ff;
            count_in  = count_ff + ONE;
            status_in = STATUS_INSERTED;
            state_in  = ST_RESP;
         end

         ST_SHIFT_DN: begin
            // close the gap: entry ptr moves one place down
            if (at_end) begin
               count_in  = count_ff - ONE;
               status_in = STATUS_REMOVED;
               state_in  = ST_RESP;
            end else begin
               wr_en   = 1'b1;
               wr_addr = ptr_dec[AW-1:0];
               ptr_in  = ptr_inc;
            end
         end

         ST_LIST: begin
            if (rsp_free) begin
               rsp_load        = 1'b1;
               rsp_data.status = STATUS_LISTED;
               rsp_data.value  = rd_data;
               rsp_data.last   = list_last;
               if (list_last) begin
                  state_in = ST_IDLE;
               end else if (func_ff == FUNC_LIST_ASC) begin
                  ptr_in = ptr_inc;
               end else begin
                  ptr_in = ptr_dec;
               end
            end
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read data for the next pointer arrives in the following cycle
      rd_addr = ptr_in[AW-1:0];
   end

endmodule

@@ design/sorted_key_set_engine_top.sv @@
// sorted key set engine: top level with response register
//
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order.
// Requests arrive on req_ch (func, key) and results leave on rsp_ch
// (status, value, last, occupancy), both valid/ready channels.
// One request is worked at a time; req_ch.ready is high only while idle.
// Insert: a linear search, one table entry per cycle, then a shift of the
// larger keys one entry per cycle; a duplicate is caught in the search.
// Remove: search plus closing the gap.
// Listing: the keys go out in order, one key per cycle while the receiver
// takes them; the last key carries last = 1.
// Insert, remove and an empty listing give one result each.
// A new request can be taken the cycle after the last result is loaded.
// A stall on rsp_ch holds the result register and the listing/result states.
// Reset empties the set and drops any pending result; no clearing pass.
module sorted_key_set_engine_top
   import skse_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   skse_req_if.sink   req_ch,
   skse_rsp_if.source rsp_ch
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic               rsp_free;
   logic               rsp_load;
   rsp_type            rsp_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] rd_data;

   logic               out_valid_ff;
   rsp_type            out_ff;

   skse_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skse_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_free (rsp_free),
      .rsp_load (rsp_load),
      .rsp_data (rsp_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   // result register frees up in the same cycle it is taken
   assign rsp_free = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         out_ff <= rsp_data;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.status    = out_ff.status;
   assign rsp_ch.value     = out_ff.value;
   assign rsp_ch.last      = out_ff.last;
   assign rsp_ch.occupancy = out_ff.occupancy;

endmodule

@@ verif/tb_sorted_key_set_engine_top.sv @@
// testbench for the sorted key set engine: directed and random requests, scoreboard check
module tb_sorted_key_set_engine_top
   import skse_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 64;

   logic clock;
   logic reset;

   skse_req_if req_ch ();
   skse_rsp_if rsp_ch ();

   sorted_key_set_engine_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // predictor state: held keys in ascending order
   logic signed [31:0] held_keys[$];
   rsp_type            expected_rsps[$];

   int error_count;
   int cycle_count;
   bit idling_on;
   int rsp_stall_left;
   int rsp_hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void predict_request(func_type op, logic signed [31:0] k);
      int      pos;
      rsp_type r;
      r.last  = 1'b1;
      r.value = k;
      case (op)
         FUNC_INSERT: begin
            pos = 0;
            while (pos < held_keys.size() && held_keys[pos] < k)
               pos++;
            if (pos < held_keys.size() && held_keys[pos] == k) begin
               r.status = STATUS_DUPLICATE;
            end else if (held_keys.size() >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               held_keys.insert(pos, k);
               r.status = STATUS_INSERTED;
            end
            r.occupancy = 5'(held_keys.size());
            expected_rsps.push_back(r);
         end
         FUNC_REMOVE: begin
            pos = 0;
            while (pos < held_keys.size() && held_keys[pos] != k)
               pos++;
            if (pos >= held_keys.size()) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               held_keys.delete(pos);
               r.status = STATUS_REMOVED;
            end
            r.occupancy = 5'(held_keys.size());
            expected_rsps.push_back(r);
         end
         default: begin
            r.occupancy = 5'(held_keys.size());
            if (held_keys.size() == 0) begin
               r.status = STATUS_EMPTY;
               r.value  = '0;
               expected_rsps.push_back(r);
            end else begin
               r.status = STATUS_LISTED;
               for (int i = 0; i < held_keys.size(); i++) begin
                  r.value = (op == FUNC_LIST_ASC) ? held_keys[i]
                                                  : held_keys[held_keys.size() - 1 - i];
                  r.last  = (i == held_keys.size() - 1);
                  expected_rsps.push_back(r);
               end
            end
         end
      endcase
   endfunction

   task automatic send_request(func_type op, logic signed [31:0] k);
      int gap;
      gap = idling_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= op;
      req_ch.key   <= k;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(op, k);
   endtask

   // receiver: long hold-off first, then the per-item stall
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_stall_left = idling_on ? $urandom_range(0, 7) : 0;
         if (expected_rsps.size() == 0) begin
            $error("unexpected item: status %0d value %0d", rsp_ch.status, rsp_ch.value);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_ch.value);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               error_count++;
            end
            if (rsp_ch.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
               error_count++;
            end
         end
      end
   end

   function automatic logic signed [31:0] pick_key();
      int c;
      c = $urandom_range(0, 9);
      if (c <= 3 && held_keys.size() > 0)
         return held_keys[$urandom_range(0, held_keys.size() - 1)];
      if (c <= 6)
         return $signed(32'($urandom_range(0, 40))) - 32'sd20;
      if (c <= 8)
         return $signed($urandom);
      case ($urandom_range(0, 3))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   task automatic test_empty_and_extremes();
      send_request(FUNC_LIST_ASC, 32'sd0);
      send_request(FUNC_LIST_DESC, 32'sh5a5a_a5a5);
      send_request(FUNC_REMOVE, 32'sd7);
      send_request(FUNC_INSERT, 32'sh7fff_ffff);
      send_request(FUNC_INSERT, 32'sh8000_0000);
      send_request(FUNC_INSERT, 32'sd0);
      send_request(FUNC_INSERT, -32'sd1);
      send_request(FUNC_INSERT, 32'sh7fff_ffff);
      send_request(FUNC_LIST_DESC, 32'shffff_ffff);
      send_request(FUNC_REMOVE, 32'sh8000_0000);
      send_request(FUNC_REMOVE, -32'sd1);
      send_request(FUNC_REMOVE, 32'sd42);
   endtask

   task automatic test_full_table();
      for (int j = 0; j < CAPACITY - 2; j++)
         send_request(FUNC_INSERT, 32'(j * 1000 + 1 - 7000));
      send_request(FUNC_INSERT, 32'sd12345);
      // a present key in a full table is still a duplicate
      send_request(FUNC_INSERT, 32'sd0);
      send_request(FUNC_LIST_ASC, 32'sd3);
   endtask

   task automatic test_receiver_hold_off();
      rsp_hold_left = 250;
      send_request(FUNC_LIST_DESC, 32'sd0);
      send_request(FUNC_REMOVE, 32'sh7fff_ffff);
      send_request(FUNC_INSERT, 32'sd5);
      send_request(FUNC_LIST_ASC, 32'sd0);
      send_request(FUNC_REMOVE, 32'sd5);
      send_request(FUNC_INSERT, 32'sh7fff_ffff);
   endtask

   task automatic test_random_traffic(int count);
      int       r;
      bit       growing;
      func_type op;
      for (int i = 0; i < count; i++) begin
         // first stretch runs back to back on both sides
         idling_on = (i >= 60);
         growing   = ((i / 40) % 2) == 0;
         r = $urandom_range(0, 99);
         if (r < (growing ? 65 : 25))
            op = FUNC_INSERT;
         else if (r < (growing ? 85 : 80))
            op = FUNC_REMOVE;
         else
            op = func_type'($urandom_range(2, 3));
         send_request(op, (op == FUNC_INSERT || op == FUNC_REMOVE) ? pick_key()
                                                                   : $signed($urandom));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_INSERT;
      req_ch.key     = '0;
      rsp_ch.ready   = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      idling_on      = 1'b1;
      rsp_stall_left = 0;
      rsp_hold_left  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_full_table();
      test_receiver_hold_off();
      test_random_traffic(330);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
